// File: hw/rtl/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned BUTTONS_DEFAULT = 2;
  localparam int unsigned BUTTONS_MAX     = 16;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [31:0] SHORT_RESET    = 32'd1000;
  localparam logic [31:0] LONG_RESET     = 32'd1000;
  localparam logic [31:0] FACTORY_RESET  = 32'd5000;
  localparam logic [15:0] MASK_RESET     = 16'd3;
  localparam logic [3:0]  RSTBTN_RESET   = 4'd0;

  localparam int unsigned ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_SHORT    = 3'd1,
    REG_LONG     = 3'd2,
    REG_FACTORY  = 3'd3,
    REG_MASK     = 3'd4,
    REG_RSTBTN   = 3'd5
  } reg_index_e;

  typedef enum logic [1:0] {
    EV_SHORT   = 2'd0,
    EV_LONG    = 2'd1,
    EV_FACTORY = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic        pressed;
    logic [31:0] start;
    logic [31:0] last;
    logic        long_sent;
    logic        factory_sent;
  } btn_state_t;

  typedef struct packed {
    event_kind_e kind;
    logic [3:0]  button;
    logic [31:0] duration;
  } result_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

endpackage

// File: hw/rtl/bpc_state_mem.sv
`timescale 1ns / 1ps

module bpc_state_mem
  import bpc_pkg::*;
#(
  parameter int unsigned BUTTONS = BUTTONS_DEFAULT,
  parameter int unsigned IDX_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] raddr_i,
  output btn_state_t       rdata_o,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  btn_state_t       wdata_i
);

  btn_state_t         mem [BUTTONS];
  logic [BUTTONS-1:0] written_q;
  btn_state_t         rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (we_i) begin
      written_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // write-first: a write to the entry being read is seen by the read
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else if (written_q[raddr_i]) begin
      rdata_q <= mem[raddr_i];
    end else begin
      rdata_q <= '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bpc_out_fifo.sv
`timescale 1ns / 1ps

module bpc_out_fifo
  import bpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  result_t               push_data_i,
  input  logic                  pop_i,
  output logic                  not_empty_o,
  output result_t               head_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  result_t               buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop_i);
    cnt_d    = cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign not_empty_o = (cnt_q != '0);
  assign head_o      = buf_q[rd_ptr_q];
  assign count_o     = cnt_q;

endmodule

// File: hw/rtl/button_press_classifier.sv
`timescale 1ns / 1ps

// Button press classifier: debounced short press, long press and factory reset events.
// Input channel (in_valid_i / in_stall_o) takes one poll sample per transfer: button
// index, raw pin level and the current millisecond time. Output channel
// (out_valid_o / out_stall_i) gives at most one event per sample, in sample order.
// Samples for buttons at or above BUTTONS give no event.
// Per-button state lives in a one-entry-per-button memory with a registered read port;
// the entry is read when a sample is taken and written back the next cycle, and a
// write-first read port forwards an update to a back-to-back sample of the same button.
// Events pass from the sample registers into the output buffer; out_valid_o follows
// the buffer's registered count. Throughput: one sample per cycle while in_stall_o is
// low, set by the single read/modify/write pass per sample.
// Events queue in a four-entry output buffer; when the receiver stalls, in_stall_o
// rises once the buffer plus the sample in flight could overflow it.
// Reset clears all button state and loads the register defaults (debounce 50 ms,
// short limit 1000 ms, long 1000 ms, factory 5000 ms, active-low mask 3, reset
// button 0). Registers sit on the APB port at byte address 4*i; the user must write
// them only while the block is idle, as the block itself does not enforce this.
module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int unsigned BUTTONS = BUTTONS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        button_index_i,
  input  logic              pin_level_i,
  input  logic [31:0]       now_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_kind_o,
  output logic [3:0]        event_button_o,
  output logic [31:0]       duration_ms_o
);

  localparam int unsigned IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  logic [15:0] debounce_q;
  logic [31:0] short_q;
  logic [31:0] long_q;
  logic [31:0] factory_q;
  logic [15:0] mask_q;
  logic [3:0]  rstbtn_q;

  reg_index_e reg_sel;
  logic       cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      short_q    <= SHORT_RESET;
      long_q     <= LONG_RESET;
      factory_q  <= FACTORY_RESET;
      mask_q     <= MASK_RESET;
      rstbtn_q   <= RSTBTN_RESET;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_DEBOUNCE: debounce_q <= pwdata[15:0];
        REG_SHORT:    short_q    <= pwdata;
        REG_LONG:     long_q     <= pwdata;
        REG_FACTORY:  factory_q  <= pwdata;
        REG_MASK:     mask_q     <= pwdata[15:0];
        REG_RSTBTN:   rstbtn_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE: prdata = {16'd0, debounce_q};
      REG_SHORT:    prdata = short_q;
      REG_LONG:     prdata = long_q;
      REG_FACTORY:  prdata = factory_q;
      REG_MASK:     prdata = {16'd0, mask_q};
      REG_RSTBTN:   prdata = {28'd0, rstbtn_q};
      default:      prdata = '0;
    endcase
  end

  // sample transfer and read stage
  logic                  in_xfer;
  logic                  in_range;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic                  s1_valid_q;
  logic [3:0]            s1_btn_q;
  logic                  s1_level_q;
  logic [31:0]           s1_now_q;

  assign in_range   = ({1'b0, button_index_i} < 5'(BUTTONS));
  assign in_stall_o = ((fifo_cnt + FIFO_CNT_W'(s1_valid_q)) >= FIFO_CNT_W'(FIFO_DEPTH));
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_btn_q   <= button_index_i;
      s1_level_q <= pin_level_i;
      s1_now_q   <= now_ms_i;
    end
  end

  btn_state_t st_rd;
  btn_state_t st_wr;

  bpc_state_mem #(
    .BUTTONS (BUTTONS),
    .IDX_W   (IDX_W)
  ) u_state_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (button_index_i[IDX_W-1:0]),
    .rdata_o (st_rd),
    .we_i    (s1_valid_q),
    .waddr_i (s1_btn_q[IDX_W-1:0]),
    .wdata_i (st_wr)
  );

  // classify and write back
  logic        active;
  logic [31:0] since_change;
  logic [31:0] dur;
  logic        emit;
  result_t     res;

  always_comb begin
    active       = mask_q[s1_btn_q] ? !s1_level_q : s1_level_q;
    since_change = s1_now_q - st_rd.last;
    dur          = s1_now_q - st_rd.start;
    st_wr        = st_rd;
    emit         = 1'b0;
    res.kind     = EV_SHORT;
    res.button   = s1_btn_q;
    res.duration = dur;
    if (since_change < {16'd0, debounce_q}) begin
      st_wr = st_rd;
    end else if (active && !st_rd.pressed) begin
      st_wr.pressed      = 1'b1;
      st_wr.start        = s1_now_q;
      st_wr.last         = s1_now_q;
      st_wr.long_sent    = 1'b0;
      st_wr.factory_sent = 1'b0;
    end else if (st_rd.pressed) begin
      if (!active) begin
        st_wr.pressed = 1'b0;
        st_wr.last    = s1_now_q;
        if (!st_rd.long_sent && (dur < short_q)) begin
          emit     = 1'b1;
          res.kind = EV_SHORT;
        end
      end else if ((s1_btn_q == rstbtn_q) && (dur >= factory_q) && !st_rd.factory_sent) begin
        st_wr.factory_sent = 1'b1;
        emit               = 1'b1;
        res.kind           = EV_FACTORY;
      end else if ((dur >= long_q) && !st_rd.long_sent) begin
        st_wr.long_sent = 1'b1;
        emit            = 1'b1;
        res.kind        = EV_LONG;
      end
    end
  end

  // event buffer
  logic    out_xfer;
  result_t head;

  assign out_xfer = out_valid_o && !out_stall_i;

  bpc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q && emit),
    .push_data_i (res),
    .pop_i       (out_xfer),
    .not_empty_o (out_valid_o),
    .head_o      (head),
    .count_o     (fifo_cnt)
  );

  assign event_kind_o   = head.kind;
  assign event_button_o = head.button;
  assign duration_ms_o  = head.duration;

endmodule
